>>> design/itq_pkg.sv
// Shared types and constants for the idle trim qualifier.
// Holds the transfer payload structs, request/cause codes and register defaults.
// No dependencies; every other design file depends on this package.
package itq_pkg;

    // Width of the wrapping millisecond clock used for all time differences.
    localparam int TIME_BITS = 48;
    typedef logic [TIME_BITS-1:0] t_time;

    localparam int NOW_W      = 48;
    localparam int PIX_W      = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Frames are kept pre-scaled by frames-per-minute so no multiplier sits on the counter.
    localparam int                FPM_SCALE = 60000;
    localparam int                SCALE_W   = 48;
    typedef logic [SCALE_W-1:0]   t_scaled;

    // Request kinds.
    localparam logic [1:0] REQ_FRAME = 2'd0;
    localparam logic [1:0] REQ_CHECK = 2'd1;
    localparam logic [1:0] REQ_FORCE = 2'd2;

    // Trim causes.
    localparam logic [2:0] CAUSE_NONE   = 3'd0;
    localparam logic [2:0] CAUSE_QUIET  = 3'd1;
    localparam logic [2:0] CAUSE_MICRO  = 3'd2;
    localparam logic [2:0] CAUSE_SPARSE = 3'd3;
    localparam logic [2:0] CAUSE_FORCED = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_GAP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MICRO_QUIET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPARSE   = 3'd4;

    // Register reset values.
    localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd30000;
    localparam logic [15:0] ATTEMPT_GAP_RST  = 16'd3000;
    localparam logic [15:0] MICRO_QUIET_RST  = 16'd2500;
    localparam logic [15:0] MIN_WINDOW_RST   = 16'd5000;
    localparam logic [15:0] MAX_SPARSE_RST   = 16'd240;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [NOW_W-1:0] now_ms;
        logic [PIX_W-1:0] total_pixels;
        logic [PIX_W-1:0] damaged_pixels;
    } t_req;

    typedef struct packed {
        logic       trim_go;
        logic [2:0] trim_cause;
        logic       frame_counted;
        logic       rate_sampled;
    } t_res;

endpackage

>>> design/itq_req_if.sv
// Request channel of the idle trim qualifier: valid, ready and a t_req payload.
// Depends on itq_pkg.
interface itq_req_if;
    logic          valid;
    logic          ready;
    itq_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/itq_res_if.sv
// Result channel of the idle trim qualifier: valid, ready and a t_res payload.
// Depends on itq_pkg.
interface itq_res_if;
    logic          valid;
    logic          ready;
    itq_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/idle_trim_qualifier_core.sv
// Idle trim qualifier: decides from timestamped requests when a memory trim may run.
// Depends on itq_pkg, itq_req_if and itq_res_if.
//
// Usage:
// Requests arrive on i_req as valid/ready transfers. Each one is a frame damage report,
// a trim check or a forced trim, stamped with a wrapping millisecond time. Every
// request produces exactly one result transfer on o_res, in request order.
// The configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data
// while the block is idle; writes to unused indexes are dropped.
// A request is captured in the input register at its transfer, it is evaluated against
// the stored state once the output register can take its result, and that result is
// held in the output register from then on until the receiver takes it.
// Throughput is one request per cycle while o_res keeps up. The whole evaluation,
// including the one 17 x TIME_BITS multiply of the sparse-rate test, is a single
// combinational step between the input register and the output and state registers.
// When the receiver stalls, the result stays in the output register, one more request
// is still taken into the input register, and only then does i_req.ready fall.
// Synchronous reset empties both registers, clears all timestamps and the frame
// counter, and loads the register defaults.
module idle_trim_qualifier_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    itq_req_if.sink                          i_req,
    itq_res_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [itq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [itq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import itq_pkg::*;

    // Product of (max_sparse_fpm + 1) and the window length.
    localparam int RP_W  = TIME_BITS + 17;
    // Width of 50 * damaged_pixels + 49.
    localparam int D50_W = PIX_W + 6;

    // Configuration registers.
    logic [31:0] r_idle_timeout;
    logic [15:0] r_attempt_gap;
    logic [15:0] r_brief_quiet;
    logic [15:0] r_min_window;
    logic [15:0] r_max_sparse;

    // Input register.
    logic r_in_valid;
    t_req r_req;

    // Qualifier state.
    t_time             r_last_activity, n_last_activity;
    t_time             r_last_attempt,  n_last_attempt;
    t_time             r_window_start,  n_window_start;
    logic [CNT_W-1:0]  r_frames,        n_frames;
    t_scaled           r_fscaled,       n_fscaled;

    // Output register.
    logic r_out_valid;
    t_res r_res, n_res;

    logic              proc_fire;
    t_time             now_t;
    t_time             attempt_el;
    t_time             quiet_for;
    t_time             window;
    logic [D50_W-1:0]  dam50;
    logic [16:0]       max_p1;
    logic [RP_W-1:0]   rate_prod;
    logic              significant;
    logic              gap_ok;
    logic              quiet;
    logic              micro;
    logic              sample;
    logic              sparse;

    // The input register advances whenever its item can move into the output register.
    assign proc_fire   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || proc_fire;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= IDLE_TIMEOUT_RST;
            r_attempt_gap  <= ATTEMPT_GAP_RST;
            r_brief_quiet  <= MICRO_QUIET_RST;
            r_min_window   <= MIN_WINDOW_RST;
            r_max_sparse   <= MAX_SPARSE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data;
                CFG_ATTEMPT_GAP:  r_attempt_gap  <= i_cfg_data[15:0];
                CFG_MICRO_QUIET:  r_brief_quiet  <= i_cfg_data[15:0];
                CFG_MIN_WINDOW:   r_min_window   <= i_cfg_data[15:0];
                CFG_MAX_SPARSE:   r_max_sparse   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Time differences wrap modulo 2^TIME_BITS through the width of t_time.
    always_comb begin
        now_t      = t_time'(r_req.now_ms);
        attempt_el = now_t - r_last_attempt;
        quiet_for  = now_t - r_last_activity;
        window     = now_t - r_window_start;

        // damaged >= floor(total/50) is the same as total <= 50*damaged + 49.
        dam50 = (D50_W'(r_req.damaged_pixels) << 5) + (D50_W'(r_req.damaged_pixels) << 4)
              + (D50_W'(r_req.damaged_pixels) << 1) + D50_W'(49);
        significant = (r_req.total_pixels != '0)
                   && ((r_req.damaged_pixels == '0)
                       || (D50_W'(r_req.total_pixels) <= dam50));

        gap_ok = attempt_el >= t_time'(r_attempt_gap);
        quiet  = quiet_for >= t_time'(r_idle_timeout);
        micro  = quiet_for >= t_time'(r_brief_quiet);
        sample = window >= t_time'(r_min_window);

        // The rate is sparse when frames*60000 < (max+1)*window. A zero window never
        // passes this test, so it needs no case of its own.
        max_p1    = {1'b0, r_max_sparse} + 17'd1;
        rate_prod = RP_W'(max_p1) * RP_W'(window);
        sparse    = sample && (RP_W'(r_fscaled) < rate_prod);
    end

    always_comb begin
        n_last_activity = r_last_activity;
        n_last_attempt  = r_last_attempt;
        n_window_start  = r_window_start;
        n_frames        = r_frames;
        n_fscaled       = r_fscaled;
        n_res           = '0;
        n_res.trim_cause = CAUSE_NONE;

        if (proc_fire) begin
            unique case (r_req.req_type)
                REQ_FRAME: begin
                    if (significant) begin
                        n_last_activity     = now_t;
                        n_res.frame_counted = 1'b1;
                        // The counter saturates; the scaled copy stops with it.
                        if (r_frames != '1) begin
                            n_frames  = r_frames + CNT_W'(1);
                            n_fscaled = r_fscaled + SCALE_W'(FPM_SCALE);
                        end
                    end
                end
                REQ_CHECK: begin
                    // A check inside the attempt gap changes nothing and reports zeros.
                    if (gap_ok) begin
                        if (sample) begin
                            n_frames           = '0;
                            n_fscaled          = '0;
                            n_window_start     = now_t;
                            n_res.rate_sampled = 1'b1;
                        end
                        priority if (quiet) begin
                            n_res.trim_cause = CAUSE_QUIET;
                        end else if (micro) begin
                            n_res.trim_cause = CAUSE_MICRO;
                        end else if (sparse) begin
                            n_res.trim_cause = CAUSE_SPARSE;
                        end else begin
                            n_res.trim_cause = CAUSE_NONE;
                        end
                        if (quiet || micro || sparse) begin
                            n_res.trim_go  = 1'b1;
                            n_last_attempt = now_t;
                        end
                    end
                end
                REQ_FORCE: begin
                    n_res.trim_go    = 1'b1;
                    n_res.trim_cause = CAUSE_FORCED;
                    n_last_attempt   = now_t;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_last_activity <= '0;
            r_last_attempt  <= '0;
            r_window_start  <= '0;
            r_frames        <= '0;
            r_fscaled       <= '0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end

            if (proc_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            r_last_activity <= n_last_activity;
            r_last_attempt  <= n_last_attempt;
            r_window_start  <= n_window_start;
            r_frames        <= n_frames;
            r_fscaled       <= n_fscaled;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
        if (proc_fire) begin
            r_res <= n_res;
        end
    end

endmodule

>>> tb/tb_idle_trim_qualifier_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for idle_trim_qualifier_core: random and directed requests
// with a per-request predictor of the trim decision. Depends on itq_pkg, itq_req_if,
// itq_res_if and the design itself.
module tb_idle_trim_qualifier_core;
    import itq_pkg::*;

    // Run limits. The slowest legal run is far below the cycle limit.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 6;

    // A frame counts when its damage reaches this share of the buffer.
    localparam logic [63:0] DAMAGE_PCT = 64'd2;
    localparam logic [63:0] PCT_BASE   = 64'd100;

    // Request code the block must ignore, and a register index it must drop.
    localparam logic [1:0]           REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    itq_req_if req_ch ();
    itq_res_if res_ch ();

    idle_trim_qualifier_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predictor copy of the configuration, starting from the reset defaults.
    logic [31:0] idle_timeout = IDLE_TIMEOUT_RST;
    logic [15:0] attempt_gap  = ATTEMPT_GAP_RST;
    logic [15:0] brief_quiet  = MICRO_QUIET_RST;
    logic [15:0] min_window   = MIN_WINDOW_RST;
    logic [15:0] max_sparse   = MAX_SPARSE_RST;

    // Predictor copy of the timestamps and the frame counter, all zero after reset.
    t_time            seen_activity = '0;
    t_time            seen_attempt  = '0;
    t_time            window_open   = '0;
    logic [CNT_W-1:0] frame_tally   = '0;

    // Requests waiting to be sent and verdicts waiting for their result transfer.
    t_req queued_reqs[$];
    t_res pending_verdicts[$];
    t_res want;

    // Stimulus timeline: the generator's notion of the current millisecond.
    t_time gen_now     = '0;
    int    phase_items = 0;

    // Handshake pacing shared by the sender and receiver processes.
    bit idle_on     = 1'b1;
    bit req_taken   = 1'b0;
    int send_gap    = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    int hold_asks   = 0;
    int hold_served = 0;

    int errors = 0;
    int cycles = 0;

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The rate is sparse when frames*60000 stays below (max+1)*window. A zero window
    // is never sparse; a window longer than the scaled count always is.
    function automatic logic sparse_rate(input logic [CNT_W-1:0] frames, input t_time span);
        logic [63:0] scaled;
        scaled = 64'(frames) * 64'(FPM_SCALE);
        if (span == '0) return 1'b0;
        if (64'(span) > scaled) return 1'b1;
        return scaled < (64'(max_sparse) + 64'd1) * 64'(span);
    endfunction

    // Computes the verdict for one request and advances the predicted state.
    function automatic t_res judge_request(input t_req r);
        t_res             v;
        t_time            now;
        t_time            gap_since;
        t_time            quiet_for;
        t_time            span;
        logic [63:0]      limit;
        logic             sparse;
        logic [CNT_W-1:0] frames;
        v      = '0;
        sparse = 1'b0;
        now    = t_time'(r.now_ms);
        case (r.req_type)
            REQ_FRAME: begin
                // A report for an empty buffer is ignored outright.
                if (r.total_pixels != '0) begin
                    limit = (64'(r.total_pixels) * DAMAGE_PCT) / PCT_BASE;
                    if (r.damaged_pixels == '0 || 64'(r.damaged_pixels) >= limit) begin
                        seen_activity = now;
                        if (frame_tally != '1) frame_tally = frame_tally + CNT_W'(1);
                        v.frame_counted = 1'b1;
                    end
                end
            end
            REQ_CHECK: begin
                gap_since = now - seen_attempt;
                // Inside the attempt gap nothing moves and the verdict stays all zero.
                if (gap_since >= t_time'(attempt_gap)) begin
                    quiet_for = now - seen_activity;
                    span      = now - window_open;
                    if (span >= t_time'(min_window)) begin
                        frames          = frame_tally;
                        frame_tally     = '0;
                        window_open     = now;
                        v.rate_sampled  = 1'b1;
                        sparse          = sparse_rate(frames, span);
                    end
                    if (quiet_for >= t_time'(idle_timeout)) begin
                        v.trim_cause = CAUSE_QUIET;
                    end else if (quiet_for >= t_time'(brief_quiet)) begin
                        v.trim_cause = CAUSE_MICRO;
                    end else if (sparse) begin
                        v.trim_cause = CAUSE_SPARSE;
                    end
                    if (v.trim_cause != CAUSE_NONE) begin
                        v.trim_go    = 1'b1;
                        seen_attempt = now;
                    end
                end
            end
            REQ_FORCE: begin
                seen_attempt = now;
                v.trim_go    = 1'b1;
                v.trim_cause = CAUSE_FORCED;
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    // Sender. The offered request stays on the bus until a transfer takes it; between
    // requests the sender may sit out a random burst of cycles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_taken) begin
            // Still waiting for the block to take the current request.
        end else if (send_gap != 0) begin
            req_ch.valid <= 1'b0;
            send_gap     <= send_gap - 1;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            req_ch.valid <= 1'b0;
            send_gap     <= $urandom_range(0, 12);
        end else if (queued_reqs.size() != 0) begin
            req_ch.valid <= 1'b1;
            req_ch.data  <= queued_reqs[0];
        end else begin
            req_ch.valid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // Every request transfer is predicted on the spot, in acceptance order.
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            pending_verdicts.push_back(judge_request(req_ch.data));
            void'(queued_reqs.pop_front());
            req_taken = 1'b1;
        end
    end

    // Receiver. A long hold-off, when asked for, keeps ready low until its countdown from
    // LONG_HOLD runs out, so that the block fills up and pushes back on its request side.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_served != hold_asks) begin
            res_ch.ready <= 1'b0;
            hold_left    <= LONG_HOLD - 1;
            hold_served  <= hold_asks;
        end else if (stall_left != 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 12);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Every mismatch is printed and counted.
    task automatic compare_field(input string name, input logic [2:0] exp_v,
                                 input logic [2:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, name, exp_v, got_v);
        end
    endtask

    // Each result transfer is matched against the oldest outstanding verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, got %h",
                         $time, res_ch.data);
            end else begin
                want = pending_verdicts.pop_front();
                compare_field("trim_go", 3'(want.trim_go), 3'(res_ch.data.trim_go));
                compare_field("trim_cause", want.trim_cause, res_ch.data.trim_cause);
                compare_field("frame_counted", 3'(want.frame_counted),
                              3'(res_ch.data.frame_counted));
                compare_field("rate_sampled", 3'(want.rate_sampled),
                              3'(res_ch.data.rate_sampled));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Waits until every request has gone in and every verdict has come back, then lets
    // the pipeline run on empty before returning.
    task automatic wait_settled();
        do @(posedge i_clk);
        while (queued_reqs.size() != 0 || req_ch.valid || pending_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write per cycle; the write enable stays up across back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_IDLE_TIMEOUT: idle_timeout = val;
            CFG_ATTEMPT_GAP:  attempt_gap  = val[15:0];
            CFG_MICRO_QUIET:  brief_quiet  = val[15:0];
            CFG_MIN_WINDOW:   min_window   = val[15:0];
            CFG_MAX_SPARSE:   max_sparse   = val[15:0];
            default: begin
            end
        endcase
    endtask

    // Rewrites all registers once the block is idle. The 16-bit registers get random
    // upper data bits, which the block must drop, and a write to an unused index must
    // change nothing.
    task automatic configure(input logic [31:0] idle, input logic [15:0] gap,
                             input logic [15:0] micro, input logic [15:0] win,
                             input logic [15:0] fpm);
        wait_settled();
        write_reg(CFG_IDLE_TIMEOUT, idle);
        write_reg(CFG_ATTEMPT_GAP, {16'($urandom), gap});
        write_reg(CFG_MICRO_QUIET, {16'($urandom), micro});
        write_reg(CFG_MIN_WINDOW, {16'($urandom), win});
        write_reg(CFG_MAX_SPARSE, {16'($urandom), fpm});
        write_reg(CFG_UNUSED, $urandom);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Ignored requests do not count toward a phase's budget.
    task automatic queue_req(input logic [1:0] kind, input t_time at,
                             input logic [31:0] total, input logic [31:0] dmg);
        t_req r;
        r.req_type       = kind;
        r.now_ms         = at;
        r.total_pixels   = total;
        r.damaged_pixels = dmg;
        queued_reqs.push_back(r);
        if (kind != REQ_UNUSED && !(kind == REQ_FRAME && total == '0)) phase_items++;
    endtask

    // Buffer sizes span tiny buffers whose threshold is zero up to the full range;
    // damage clusters around the threshold so both sides of it are hit.
    task automatic pick_pixels(output logic [31:0] total, output logic [31:0] dmg);
        logic [63:0] limit;
        case ($urandom_range(0, 15))
            0:             total = '0;
            1, 2, 3, 4:    total = $urandom_range(1, 60);
            5, 6, 7, 8, 9: total = $urandom_range(61, 5000);
            10, 11, 12:    total = $urandom;
            13:            total = '1;
            default:       total = $urandom_range(5001, 10000000);
        endcase
        limit = (64'(total) * DAMAGE_PCT) / PCT_BASE;
        case ($urandom_range(0, 7))
            0:       dmg = '0;
            1:       dmg = limit[31:0];
            2:       dmg = 32'(limit + 64'd1);
            3:       dmg = 32'(limit - 64'd1);
            4:       dmg = total;
            5:       dmg = '1;
            6:       dmg = 32'(limit + {$urandom, $urandom} % (64'(total) - limit + 64'd1));
            default: dmg = $urandom;
        endcase
    endtask

    // Time step that lands on, just below, just above or somewhere around a threshold.
    function automatic t_time pick_step(input t_time thr);
        case ($urandom_range(0, 19))
            0:                      return thr - t_time'(1);
            1, 2, 3:                return thr;
            4:                      return thr + t_time'(1);
            5, 6, 7, 8:             return t_time'($urandom_range(0, 300));
            19:                     return {16'($urandom), $urandom};
            default:                return t_time'({$urandom, $urandom} % (64'(thr) * 2 + 1));
        endcase
    endfunction

    // One scene: mostly a burst of frame reports followed by trim checks placed around
    // the quiet, micro-quiet, window and gap thresholds, sometimes a forced trim; the
    // rest is noise with random kinds, times and pixel counts.
    task automatic queue_scene();
        int          n;
        logic [31:0] total;
        logic [31:0] dmg;
        t_time       thr;
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                pick_pixels(total, dmg);
                if ($urandom_range(0, 1) != 0) begin
                    total = $urandom;
                    dmg   = $urandom;
                end
                queue_req(2'($urandom_range(REQ_FRAME, REQ_UNUSED)),
                          ($urandom_range(0, 1) != 0) ? t_time'({16'($urandom), $urandom})
                                                     : gen_now + t_time'($urandom_range(0, 5000)),
                          total, dmg);
            end
        end else begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            repeat (n) begin
                gen_now += t_time'($urandom_range(0, 400));
                pick_pixels(total, dmg);
                queue_req(REQ_FRAME, gen_now, total, dmg);
            end
            case ($urandom_range(0, 3))
                0:       thr = t_time'(idle_timeout);
                1, 2:    thr = t_time'(brief_quiet);
                default: thr = t_time'(min_window);
            endcase
            gen_now += pick_step(thr);
            queue_req(REQ_CHECK, gen_now, $urandom, $urandom);
            n = $urandom_range(0, 3);
            repeat (n) begin
                gen_now += pick_step(t_time'(attempt_gap));
                queue_req(REQ_CHECK, gen_now, $urandom, $urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                gen_now += t_time'($urandom_range(0, 4000));
                queue_req(REQ_FORCE, gen_now, $urandom, $urandom);
            end
        end
    endtask

    task automatic queue_random(input int budget);
        phase_items = 0;
        while (phase_items < budget) queue_scene();
    endtask

    initial begin
        t_time t0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: quiet 30000, gap 3000, micro 2500, window 5000, sparse 240.
        // A check right after reset is still inside the attempt gap.
        queue_req(REQ_CHECK, 48'd0, '0, '0);
        // Empty buffer is ignored; full damage counts; one pixel short of the 2%
        // threshold does not, the threshold itself does.
        queue_req(REQ_FRAME, 48'd10, '0, 32'd5);
        queue_req(REQ_FRAME, 48'd20, 32'd100, '0);
        queue_req(REQ_FRAME, 48'd30, 32'd1000, 32'd19);
        queue_req(REQ_FRAME, 48'd40, 32'd1000, 32'd20);
        queue_req(REQ_FRAME, 48'd50, '1, '1);
        queue_req(REQ_FRAME, 48'd60, '1, 32'd85899344);
        queue_req(REQ_UNUSED, 48'd70, '1, '1);
        // Micro quiet fires before any window is sampled.
        queue_req(REQ_CHECK, 48'd3000, '0, '0);
        // A full-damage frame just before the check leaves only the sparse rate to fire.
        queue_req(REQ_FRAME, 48'd5990, 32'd50, '0);
        queue_req(REQ_CHECK, 48'd6000, '0, '0);
        // Full quiet wins over the sparse rate of an empty window.
        queue_req(REQ_CHECK, 48'd36000, '0, '0);
        queue_req(REQ_FORCE, 48'd36001, '0, '0);
        // A forced trim also restarts the attempt gap.
        queue_req(REQ_CHECK, 48'd38000, '0, '0);
        // Last millisecond before the wrap, then a check just after it.
        queue_req(REQ_FRAME, '1, 32'd1, '0);
        queue_req(REQ_CHECK, 48'd4000, '0, '0);
        gen_now = 48'd4000;

        // The receiver holds off while the sender keeps offering.
        hold_asks++;
        queue_random(250);

        // Rate boundary: one frame in a 1000 ms window is exactly 60 per minute, which
        // is not sparse at a limit of 59; one millisecond more makes it sparse.
        configure('1, 16'd0, 16'hFFFF, 16'd1000, 16'd59);
        t0 = gen_now + 48'd70000;
        queue_req(REQ_CHECK, t0, '0, '0);
        queue_req(REQ_CHECK, t0 + 48'd1000, '0, '0);
        queue_req(REQ_FRAME, t0 + 48'd1999, 32'd1, '0);
        queue_req(REQ_CHECK, t0 + 48'd2000, '0, '0);
        queue_req(REQ_FRAME, t0 + 48'd3000, 32'd1, '0);
        queue_req(REQ_CHECK, t0 + 48'd3001, '0, '0);
        gen_now = t0 + 48'd3001;
        queue_random(220);

        // Smallest settings: every passing check is a full-quiet trim.
        configure('0, 16'd0, 16'd0, 16'd1, 16'd0);
        queue_random(200);

        // Largest settings, with the timeline crossing the wrap of the clock.
        configure('1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        gen_now = '1 - 48'd100000;
        queue_random(200);

        // Zero minimum window: every passing check samples, and a zero-length window
        // is never sparse.
        configure($urandom_range(1, 60000), 16'd0, 16'($urandom_range(1, 10000)), 16'd0,
                  16'($urandom_range(0, 600)));
        gen_now += 48'd100;
        queue_req(REQ_FRAME, gen_now, 32'd1, '0);
        queue_req(REQ_CHECK, gen_now, '0, '0);
        queue_req(REQ_CHECK, gen_now, '0, '0);
        queue_random(200);

        // Random settings; halfway through, the sender waits for every result.
        configure(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60000),
                  16'($urandom_range(0, 8000)), 16'($urandom_range(0, 10000)),
                  16'($urandom_range(1, 20000)), 16'($urandom_range(0, 600)));
        queue_random(120);
        wait_settled();
        queue_random(120);

        // Last part at full rate on both sides.
        configure(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60000),
                  16'($urandom_range(0, 8000)), 16'($urandom_range(0, 10000)),
                  16'($urandom_range(1, 20000)), 16'($urandom_range(0, 600)));
        idle_on = 1'b0;
        queue_random(240);

        wait_settled();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
